@@ design/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  localparam logic [15:0] UNIT_REPL = 16'hFFFD;
  localparam logic [20:0] CODE_MAX  = 21'h10FFFF;
  localparam logic [20:0] PLANE1    = 21'h010000;
  localparam logic [5:0]  SUR_HIGH  = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  SUR_LOW   = 6'b110111;  // 0xDC00 >> 10

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One decoded byte: one or two code units to emit.
  typedef struct packed {
    logic        two_units;
    logic [15:0] unit0;
    logic        repl0;
    logic [15:0] unit1;
    logic        repl1;
    logic        str_end;
  } entry_t;

endpackage

@@ design/utf8_to_utf16_transcoder_core.sv @@
// UTF-8 to UTF-16 transcoder top level: front decoder, entry queue, unit serialiser.
// Path: a byte's first code unit goes into the entry queue when the byte is taken, then into
//   the output register, which holds it on out_valid while out_stall is high.
// Throughput: one byte per cycle while the queue is not full; a byte yielding two units
//   takes the single output register twice; the four-entry queue absorbs the difference.
// Reset: synchronous on rst_n low; clears the open sequence, the queue and the output valid.
module utf8_to_utf16_transcoder_core import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_string_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_replaced,
  output logic        out_run_last,
  output logic        out_string_last
);

  // Front to queue: an entry is pushed only for bytes that produce units; bytes
  // that open or extend a sequence leave nothing unless one ends or breaks, or the string ends.
  logic   q_full;
  logic   push;
  entry_t push_data;

  // Queue to back end
  logic   head_valid;
  entry_t head_data;
  logic   pop;

  u8u16_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_in    (in_byte_in),
    .in_string_end (in_string_end),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // The back end pops an entry once its last unit is loaded into the output register.
  u8u16_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_data       (head_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_replaced    (out_replaced),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

endmodule

@@ design/u8u16_front.sv @@
// Front end: accepts bytes, tracks the open sequence and classifies results.
module u8u16_front import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_byte_in,
  input  logic        in_string_end,
  output logic        in_stall,
  input  logic        q_full,
  output logic        push,
  output entry_t      push_data
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] accum_r, accum_nxt;

  logic        accept;
  logic        is_cont, is_ascii, is_l2, is_l3, is_l4;
  logic [20:0] acc_shift;
  logic [1:0]  pend_dec;
  logic [20:0] v_off;
  logic        lead_has;
  logic [15:0] lead_unit;
  logic        lead_repl;
  logic [1:0]  n_units;
  entry_t      ent;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_cont   = (in_byte_in[7:6] == 2'b10);
  assign is_ascii  = !in_byte_in[7];
  assign is_l2     = (in_byte_in[7:5] == 3'b110);
  assign is_l3     = (in_byte_in[7:4] == 4'b1110);
  assign is_l4     = (in_byte_in[7:3] == 5'b11110);
  assign acc_shift = {accum_r[14:0], in_byte_in[5:0]};
  assign pend_dec  = pend_r - 2'd1;
  assign v_off     = acc_shift - PLANE1;

  always_comb begin
    pend_nxt  = pend_r;
    accum_nxt = accum_r;
    n_units   = 2'd0;
    ent       = '0;
    lead_has  = 1'b0;
    lead_unit = UNIT_REPL;
    lead_repl = 1'b1;
    ent.str_end = in_string_end;

    if (pend_r != 2'd0 && is_cont) begin
      pend_nxt  = pend_dec;
      accum_nxt = acc_shift;
      if (pend_dec == 2'd0) begin
        accum_nxt = '0;
        if (acc_shift > CODE_MAX) begin
          n_units   = 2'd1;
          ent.unit0 = UNIT_REPL;
          ent.repl0 = 1'b1;
        end else if (acc_shift < PLANE1) begin
          n_units   = 2'd1;
          ent.unit0 = acc_shift[15:0];
        end else begin
          n_units   = 2'd2;
          ent.unit0 = {SUR_HIGH, v_off[19:10]};
          ent.unit1 = {SUR_LOW, v_off[9:0]};
        end
      end else if (in_string_end) begin
        // sequence cut short by end of string
        n_units   = 2'd1;
        ent.unit0 = UNIT_REPL;
        ent.repl0 = 1'b1;
      end
    end else begin
      pend_nxt  = 2'd0;
      accum_nxt = '0;
      if (is_ascii) begin
        lead_has  = 1'b1;
        lead_unit = {8'h00, in_byte_in};
        lead_repl = 1'b0;
      end else if (is_l2 || is_l3 || is_l4) begin
        if (is_l2) begin
          pend_nxt  = 2'd1;
          accum_nxt = {16'h0, in_byte_in[4:0]};
        end else if (is_l3) begin
          pend_nxt  = 2'd2;
          accum_nxt = {17'h0, in_byte_in[3:0]};
        end else begin
          pend_nxt  = 2'd3;
          accum_nxt = {18'h0, in_byte_in[2:0]};
        end
        // a lead on the final byte leaves a truncated sequence
        lead_has = in_string_end;
      end else begin
        lead_has = 1'b1;
      end

      if (pend_r != 2'd0) begin
        // interrupted sequence: replacement first, then the new lead
        ent.unit0     = UNIT_REPL;
        ent.repl0     = 1'b1;
        ent.unit1     = lead_unit;
        ent.repl1     = lead_repl;
        ent.two_units = lead_has;
        n_units       = lead_has ? 2'd2 : 2'd1;
      end else begin
        ent.unit0 = lead_unit;
        ent.repl0 = lead_repl;
        n_units   = lead_has ? 2'd1 : 2'd0;
      end
    end

    if (n_units == 2'd2) begin
      ent.two_units = 1'b1;
    end
    if (in_string_end) begin
      pend_nxt  = 2'd0;
      accum_nxt = '0;
    end
  end

  assign push      = accept && (n_units != 2'd0);
  assign push_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      accum_r <= '0;
    end else if (accept) begin
      pend_r  <= pend_nxt;
      accum_r <= accum_nxt;
    end
  end

endmodule

@@ design/u8u16_queue.sv @@
// Short queue of decoded entries between front and back ends.
module u8u16_queue import u8u16_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_data
);

  entry_t           slot_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   cnt_r;
  logic             do_pop;

  assign full       = (cnt_r == QCW'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

endmodule

@@ design/u8u16_back.sv @@
// Back end: serialises queued entries into code units on the output register.
module u8u16_back import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  entry_t      head_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_replaced,
  output logic        out_run_last,
  output logic        out_string_last
);

  logic        sel_r, sel_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic        repl_r, repl_nxt;
  logic        rlast_r, rlast_nxt;
  logic        slast_r, slast_nxt;
  logic        load;

  assign load = head_valid && (!valid_r || !out_stall);

  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r && out_stall;
    unit_nxt  = unit_r;
    repl_nxt  = repl_r;
    rlast_nxt = rlast_r;
    slast_nxt = slast_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      unit_nxt  = sel_r ? head_data.unit1 : head_data.unit0;
      repl_nxt  = sel_r ? head_data.repl1 : head_data.repl0;
      rlast_nxt = sel_r || !head_data.two_units;
      slast_nxt = rlast_nxt && head_data.str_end;
      pop       = rlast_nxt;
      sel_nxt   = !rlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r  <= unit_nxt;
    repl_r  <= repl_nxt;
    rlast_r <= rlast_nxt;
    slast_r <= slast_nxt;
  end

  assign out_valid       = valid_r;
  assign out_code_unit   = unit_r;
  assign out_replaced    = repl_r;
  assign out_run_last    = rlast_r;
  assign out_string_last = slast_r;

endmodule

@@ tb/sv/tb_utf8_to_utf16_transcoder_core.sv @@
// Self-checking bench for the UTF-8 to UTF-16 transcoder core: directed table, random strings.
module tb_utf8_to_utf16_transcoder_core;
  import u8u16_pkg::*;

  // One UTF-16 code unit as seen on the result channel.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_last;
    logic        string_last;
  } utf16_unit_t;

  // Directed table row. When hand_typed is set, the units owed are typed in the row
  // (one or two, run_last and string_last implied); otherwise the decoder model supplies them.
  typedef struct packed {
    logic [7:0]  byte_val;
    logic        last;
    logic        hand_typed;
    logic [1:0]  n_units;
    logic [15:0] unit0;
    logic        repl0;
    logic [15:0] unit1;
    logic        repl1;
  } byte_row_t;

  localparam int N_DIRECTED = 24;
  localparam byte_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // ASCII extremes, then invalid leads on their own
    '{8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 2'd1, 16'h007F, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b1, 2'd1, UNIT_REPL, 1'b1, 16'h0000, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 2'd1, UNIT_REPL, 1'b1, 16'h0000, 1'b0},
    // two- and three-byte forms
    '{8'hC2, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hA9, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'h82, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hAC, 1'b1, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // U+10FFFF, the top of the range, leaves as the highest surrogate pair
    '{8'hF4, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'h8F, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b1, 2'd2, 16'hDBFF, 1'b0, 16'hDFFF, 1'b0},
    // 0x1FFFFF is beyond range
    '{8'hF7, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b1, 2'd1, UNIT_REPL, 1'b1, 16'h0000, 1'b0},
    // sequence cut by ASCII: replacement, then the ASCII byte itself
    '{8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'h41, 1'b0, 1'b1, 2'd2, UNIT_REPL, 1'b1, 16'h0041, 1'b0},
    // cut by a new lead that the string end then truncates
    '{8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hF0, 1'b1, 1'b1, 2'd2, UNIT_REPL, 1'b1, UNIT_REPL, 1'b1},
    // a properly encoded U+FFFD is not flagged as replaced
    '{8'hEF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{8'hBD, 1'b1, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}
  };

  // Idle percentages per phase: sender-heavy on the receiver, then swapped, then none.
  localparam int SRC_IDLE_PCT [3] = '{16, 47, 0};
  localparam int SNK_IDLE_PCT [3] = '{47, 16, 0};
  localparam int RANDOM_PER_PHASE = 225;  // bytes of random stimulus per phase
  localparam int HOLD_OFF_CYCLES  = 80;   // long receiver hold-off, well past queue depth
  // No-progress limit: random stalls at 47 % rarely run long and the hold-off is far shorter,
  // so a run of idle cycles that reaches the limit can only mean a hang.
  localparam int STUCK_LIMIT      = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_in;
  logic        in_string_end;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_code_unit;
  logic        out_replaced;
  logic        out_run_last;
  logic        out_string_last;

  // Decoder model state
  logic [1:0]  cont_left;
  logic [20:0] code_bits;
  utf16_unit_t byte_units [$];   // units caused by the byte just decoded
  utf16_unit_t owed_units [$];   // units the block still owes, oldest first

  int idle_phase   = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int bytes_sent        = 0;
  int units_seen        = 0;
  int repl_seen         = 0;
  int pair_halves_seen  = 0;
  int bad_units         = 0;
  int stuck_cycles      = 0;

  utf8_to_utf16_transcoder_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .in_string_end   (in_string_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_replaced    (out_replaced),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // At most two units leave per byte.
  function automatic void push_unit(logic [15:0] cu, logic rep);
    if (byte_units.size() < 2)
      byte_units.insert(byte_units.size(), utf16_unit_t'{cu, rep, 1'b0, 1'b0});
  endfunction

  // A byte seen with no sequence open: ASCII, a lead, or garbage.
  function automatic void open_sequence(logic [7:0] b);
    if (!b[7]) begin
      push_unit({8'h00, b}, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      code_bits = {16'h0000, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      code_bits = {17'h00000, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      code_bits = {18'h00000, b[2:0]};
      cont_left = 2'd3;
    end else begin
      push_unit(UNIT_REPL, 1'b1);
    end
  endfunction

  // Complete code point: BMP as is, supplementary as a pair, out of range replaced.
  function automatic void emit_code_point(logic [20:0] cp);
    logic [20:0] offs;
    if (cp > CODE_MAX) begin
      push_unit(UNIT_REPL, 1'b1);
    end else if (cp < PLANE1) begin
      push_unit(cp[15:0], 1'b0);
    end else begin
      offs = cp - PLANE1;
      push_unit({SUR_HIGH, offs[19:10]}, 1'b0);
      push_unit({SUR_LOW, offs[9:0]}, 1'b0);
    end
  endfunction

  // Works out the units one accepted byte causes, leaving them in byte_units.
  function automatic void transcode_byte(logic [7:0] b, logic last);
    utf16_unit_t tail_u;
    byte_units.delete();
    if (cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        code_bits = {code_bits[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          emit_code_point(code_bits);
          code_bits = '0;
        end
      end else begin
        // interrupted: replace, drop, then treat the byte as a fresh lead
        push_unit(UNIT_REPL, 1'b1);
        cont_left = 2'd0;
        code_bits = '0;
        open_sequence(b);
      end
    end else begin
      open_sequence(b);
    end
    if (last) begin
      if (cont_left != 2'd0) push_unit(UNIT_REPL, 1'b1);  // truncated by string end
      cont_left = 2'd0;
      code_bits = '0;
    end
    if (byte_units.size() > 0) begin
      tail_u = byte_units.pop_back();
      tail_u.run_last    = 1'b1;
      tail_u.string_last = last;
      byte_units.insert(byte_units.size(), tail_u);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one byte, waits for its transaction, then runs the model on it. When
  // take_model is set, the model's units are queued as owed.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit take_model);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_in    <= b;
    in_string_end <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bytes_sent++;
    transcode_byte(b, last);
    if (take_model)
      foreach (byte_units[k]) owed_units.insert(owed_units.size(), byte_units[k]);
  endtask

  // One random chunk: mostly well-formed sequences with random content, some cut short,
  // the rest single noise bytes.
  task automatic send_random_chunk();
    logic [7:0]  seq [4];
    logic [20:0] cp;
    int          kind;
    int          len;
    int          keep;
    logic        end_here;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0), 1'b1);
      return;
    end
    len = (kind < 70) ? $urandom_range(4, 1) : $urandom_range(4, 2);
    cp  = 21'($urandom);
    // keep most four-byte forms inside the legal supplementary range
    if (len == 4 && $urandom_range(3) != 0) cp = PLANE1 + 21'($urandom_range(21'hFFFFF));
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    if (kind < 70) begin
      keep     = len;
      end_here = ($urandom_range(5) == 0);
    end else begin
      keep     = $urandom_range(len - 1, 1);  // broken: the next byte or the end cuts it
      end_here = ($urandom_range(1) == 1);
    end
    for (int i = 0; i < keep; i++) send_byte(seq[i], end_here && (i == keep - 1), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, plus one long hold-off at the start of the no-idle phase so
  // that the queue fills and in_stall has to rise.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (int held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result transaction against the oldest owed unit
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    utf16_unit_t got;
    utf16_unit_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = utf16_unit_t'{out_code_unit, out_replaced, out_run_last, out_string_last};
      units_seen++;
      if (got.replaced) repl_seen++;
      if (got.code_unit[15:11] == 5'b11011) pair_halves_seen++;
      if (owed_units.size() == 0) begin
        bad_units++;
        if (bad_units <= 10)
          $display("ERROR: unit %h repl %b run_last %b string_last %b with none owed",
                   got.code_unit, got.replaced, got.run_last, got.string_last);
      end else begin
        want = owed_units.pop_front();
        if (got !== want) begin
          bad_units++;
          if (bad_units <= 10)
            $display({"ERROR: unit %0d expected %h/%b/%b/%b got %h/%b/%b/%b",
                      " (code_unit/replaced/run_last/string_last)"},
                     units_seen, want.code_unit, want.replaced, want.run_last,
                     want.string_last, got.code_unit, got.replaced, got.run_last,
                     got.string_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when neither channel moves for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("ERROR: no transaction for %0d cycles, %0d units still owed",
             STUCK_LIMIT, owed_units.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    byte_row_t row;
    int        phase_start;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_byte_in    <= 8'h00;
    in_string_end <= 1'b0;
    cont_left     = 2'd0;
    code_bits     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      idle_phase   = ph;
      src_idle_pct = SRC_IDLE_PCT[ph];
      snk_idle_pct = SNK_IDLE_PCT[ph];
      if (ph == 0) begin
        // directed table: typed rows carry their own units, the rest use the model
        for (int r = 0; r < N_DIRECTED; r++) begin
          row = DIRECTED_ROWS[r];
          send_byte(row.byte_val, row.last, !row.hand_typed);
          if (row.hand_typed) begin
            if (row.n_units == 2'd2) begin
              owed_units.insert(owed_units.size(),
                                utf16_unit_t'{row.unit0, row.repl0, 1'b0, 1'b0});
              owed_units.insert(owed_units.size(),
                                utf16_unit_t'{row.unit1, row.repl1, 1'b1, row.last});
            end else begin
              owed_units.insert(owed_units.size(),
                                utf16_unit_t'{row.unit0, row.repl0, 1'b1, row.last});
            end
          end
        end
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RANDOM_PER_PHASE) send_random_chunk();
    end
    in_valid <= 1'b0;

    // drain, then give the two-stage pipe time to show any stray unit
    while (owed_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run: %0d bytes (%0d from the table) through three idle phases and a hold-off.",
             bytes_sent, N_DIRECTED);
    $display("Checked %0d units: %0d replacements, %0d surrogate halves, %0d mismatches.",
             units_seen, repl_seen, pair_halves_seen, bad_units);
    if (bad_units == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
